### sv/ihex4l_pkg.sv
// Shared types, record codes and the hex nibble decode for the four-lane HEX parser.
`default_nettype none

package ihex4l_pkg;

  // Number of character streams; one byte of each data word per lane.
  localparam int LANES = 4;

  // Character position of the first character after the record header.
  localparam logic [9:0] HDR_END = 10'd9;

  // Record type codes that the parser understands.
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  // Kind of result item.
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EOF      = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_END      = 2'd3
  } kind_t;

  // One character position of all four streams.
  typedef struct packed {
    logic [7:0] lane0_char;
    logic [7:0] lane1_char;
    logic [7:0] lane2_char;
    logic [7:0] lane3_char;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word_address;
    logic [7:0]  word_index;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic        last_in_record;
  } out_item_t;

  // Decode one ASCII hex digit; anything else reads as zero.
  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/ihex4l_core.sv
// Record parser state and per-position decode for the four-lane HEX parser.
`default_nettype none

module ihex4l_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire ihex4l_pkg::in_item_t item,
  output logic                      produced,
  output ihex4l_pkg::out_item_t     result
);
  import ihex4l_pkg::*;

  logic [9:0]  char_position, char_position_next;
  logic [7:0]  pair_count, pair_count_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [15:0] upper_offset, upper_offset_next;
  logic [15:0] offset_build, offset_build_next;
  logic [15:0] high_nibbles, high_nibbles_next;
  logic [7:0]  words_done, words_done_next;
  logic        finished, finished_next;

  logic [3:0]  n0, n1, n2, n3;
  logic [7:0]  b0, b1, b2, b3;
  logic [9:0]  off;
  logic [9:0]  span;
  logic [7:0]  kind_full;
  logic        last;

  // Decode the current position's nibbles and the bytes they would complete.
  always_comb begin
    n0 = nib(item.lane0_char);
    n1 = nib(item.lane1_char);
    n2 = nib(item.lane2_char);
    n3 = nib(item.lane3_char);
    b0 = {high_nibbles[3:0], n0};
    b1 = {high_nibbles[7:4], n1};
    b2 = {high_nibbles[11:8], n2};
    b3 = {high_nibbles[15:12], n3};
    off = char_position - HDR_END;
    span = {1'b0, pair_count, 1'b0};
    kind_full = record_kind | {4'd0, n0};
    last = ({1'b0, words_done} + 9'd1) == {1'b0, pair_count};
  end

  // Work out the next state and the result of this position.
  always_comb begin
    char_position_next  = char_position;
    pair_count_next     = pair_count;
    record_address_next = record_address;
    record_kind_next    = record_kind;
    upper_offset_next   = upper_offset;
    offset_build_next   = offset_build;
    high_nibbles_next   = high_nibbles;
    words_done_next     = words_done;
    finished_next       = finished;
    produced            = 1'b0;
    result              = '0;

    if (!finished) begin
      if (char_position == 10'd0) begin
        // Record start: a NUL ends the input.
        if (item.lane0_char == 8'h00) begin
          produced      = 1'b1;
          result.kind   = KIND_END;
          finished_next = 1'b1;
        end else begin
          char_position_next = 10'd1;
        end
      end else if (char_position < HDR_END) begin
        // Header: count, address and record type from lane 0.
        char_position_next = char_position + 10'd1;
        case (char_position)
          10'd1: pair_count_next = {n0, 4'd0};
          10'd2: pair_count_next = pair_count | {4'd0, n0};
          10'd3, 10'd4, 10'd5, 10'd6: record_address_next = {record_address[11:0], n0};
          10'd7: record_kind_next = {n0, 4'd0};
          default: begin
            record_kind_next  = kind_full;
            words_done_next   = 8'd0;
            offset_build_next = 16'd0;
            if (kind_full == REC_EOF) begin
              produced      = 1'b1;
              result.kind   = KIND_EOF;
              finished_next = 1'b1;
            end else if (kind_full == REC_EXT_LIN) begin
              if (pair_count == 8'd0) begin
                upper_offset_next = 16'd0;
              end
            end else if (kind_full != REC_DATA) begin
              produced      = 1'b1;
              result.kind   = KIND_BAD_TYPE;
              finished_next = 1'b1;
            end
          end
        endcase
      end else if (off < span) begin
        char_position_next = char_position + 10'd1;
        if (!off[0]) begin
          // First character of a pair: hold the high nibbles.
          high_nibbles_next = {n3, n2, n1, n0};
        end else begin
          words_done_next = words_done + 8'd1;
          if (record_kind == REC_DATA) begin
            // Second character: emit one data word.
            produced              = 1'b1;
            result.kind           = KIND_DATA;
            result.word_address   = {upper_offset, record_address};
            result.word_index     = words_done;
            result.data_byte0     = b0;
            result.data_byte1     = b1;
            result.data_byte2     = b2;
            result.data_byte3     = b3;
            result.last_in_record = last;
          end else begin
            // Accumulate the extended linear address; apply it after the last pair.
            offset_build_next = {offset_build[7:0], b0};
            if (last) begin
              upper_offset_next = {offset_build[7:0], b0};
            end
          end
        end
      end else if (off == span) begin
        // First checksum character.
        char_position_next = char_position + 10'd1;
      end else begin
        // Second checksum character: next record starts.
        char_position_next = 10'd0;
      end
    end
  end

  // Hold parser state; advance once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= 10'd0;
      pair_count     <= 8'd0;
      record_address <= 16'd0;
      record_kind    <= 8'd0;
      upper_offset   <= 16'd0;
      offset_build   <= 16'd0;
      high_nibbles   <= 16'd0;
      words_done     <= 8'd0;
      finished       <= 1'b0;
    end else if (advance) begin
      char_position  <= char_position_next;
      pair_count     <= pair_count_next;
      record_address <= record_address_next;
      record_kind    <= record_kind_next;
      upper_offset   <= upper_offset_next;
      offset_build   <= offset_build_next;
      high_nibbles   <= high_nibbles_next;
      words_done     <= words_done_next;
      finished       <= finished_next;
    end
  end

endmodule

`default_nettype wire

### sv/intel_hex_four_lane_parser.sv
// Top level of the four-lane HEX parser: input register, parser core, result register.
//
// Usage:
//   Input channel item/item_valid/item_ready carries one character position of
//   all four streams per item. Output channel result/result_valid/result_ready
//   carries data words, the end-of-file marker, a bad-record-type error or the
//   end-of-input marker. A position yields zero or one result item.
//   Throughput: one item per cycle while the receiver takes results, set by the
//   single decode stage between the input register and the result register.
//   An input item is taken into the input register, which feeds the decode;
//   the result register loads the decoded result as long as the result
//   register is free or being emptied.
//   Reset (rst, synchronous) clears the parser to a record start with a zero
//   extended offset and empties both registers.
//   When the receiver stalls, the result register holds its item and the input
//   register takes one more item if it is empty; after that item_ready drops
//   until the result is taken. After an end, error or end-of-file result, items
//   are taken and dropped until reset.
`default_nettype none

module intel_hex_four_lane_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire ihex4l_pkg::in_item_t  item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output ihex4l_pkg::out_item_t      result
);
  import ihex4l_pkg::*;

  logic      hold_valid;
  in_item_t  hold_item;
  logic      advance;
  logic      produced;
  out_item_t core_result;

  // Consume the held item when the result register is free or being emptied.
  assign advance    = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || advance;

  ihex4l_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (hold_item),
    .produced (produced),
    .result   (core_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold_item <= item;
    end
  end

  // Result register: load on a produced result, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && produced) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produced) begin
      result <= core_result;
    end
  end

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the four-lane HEX parser: record streams checked against a built-in parser model.
`timescale 1ns / 1ps

module tb;
  import ihex4l_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int error_count = 0;

  // Results the parser owes us, oldest first
  out_item_t pending_results [$];

  // Parser model state
  logic [9:0]  at_pos = '0;
  logic [7:0]  rec_count = '0;
  logic [15:0] rec_addr = '0;
  logic [7:0]  rec_type = '0;
  logic [15:0] ext_offset = '0;
  logic [15:0] ext_build = '0;
  logic [15:0] high_nib = '0;
  logic [7:0]  word_count = '0;
  logic        parse_done = 1'b0;

  intel_hex_four_lane_parser uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Value of a hex digit; other characters count as zero
  function automatic logic [3:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = rand_char();
    while (is_hex(c)) c = rand_char();
    return c;
  endfunction

  // Hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + {4'h0, v};
    return ($urandom_range(1) ? "a" : "A") + {4'h0, v} - 8'd10;
  endfunction

  // Replace a character by a random one now and then
  function automatic logic [7:0] noisy(input logic [7:0] c, input int pct);
    if ($urandom_range(99) < pct) return rand_char();
    return c;
  endfunction

  // Header or checksum position: only lane 0 matters
  function automatic in_item_t lane0_item(input logic [7:0] c);
    in_item_t it;
    it.lane0_char = c;
    it.lane1_char = rand_char();
    it.lane2_char = rand_char();
    it.lane3_char = rand_char();
    return it;
  endfunction

  // One half of a data pair: upper or lower digit of each lane's byte
  function automatic in_item_t pair_item(input logic [31:0] bytes, input bit upper, input int pct);
    in_item_t it;
    it.lane0_char = noisy(hex_char(upper ? bytes[7:4] : bytes[3:0]), pct);
    it.lane1_char = noisy(hex_char(upper ? bytes[15:12] : bytes[11:8]), pct);
    it.lane2_char = noisy(hex_char(upper ? bytes[23:20] : bytes[19:16]), pct);
    it.lane3_char = noisy(hex_char(upper ? bytes[31:28] : bytes[27:24]), pct);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 100) begin
      $display("ERROR at %0t: %s is %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Add one result to the end of the expected list
  task automatic queue_expected(input out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Advance the parser model by one character position
  task automatic track_parser(input in_item_t it);
    logic [7:0] ch [4];
    logic [7:0] b [4];
    logic [3:0] v0;
    logic [9:0] off;
    logic [9:0] span;
    logic       last;
    out_item_t  r;
    ch[0] = it.lane0_char;
    ch[1] = it.lane1_char;
    ch[2] = it.lane2_char;
    ch[3] = it.lane3_char;
    v0 = char_value(ch[0]);
    r = '0;
    if (parse_done) return;
    // record start: NUL ends the input, anything else is the start code
    if (at_pos == 10'd0) begin
      if (ch[0] == 8'h00) begin
        r.kind = KIND_END;
        parse_done = 1'b1;
        queue_expected(r);
      end else begin
        at_pos = 10'd1;
      end
      return;
    end
    // header: count, address, type
    if (at_pos < HDR_END) begin
      case (at_pos)
        10'd1: rec_count = {v0, 4'h0};
        10'd2: rec_count[3:0] = v0;
        10'd3, 10'd4, 10'd5, 10'd6: rec_addr = {rec_addr[11:0], v0};
        10'd7: rec_type = {v0, 4'h0};
        default: begin
          rec_type[3:0] = v0;
          word_count = '0;
          ext_build = '0;
          if (rec_type != REC_DATA && rec_type != REC_EXT_LIN) begin
            r.kind = (rec_type == REC_EOF) ? KIND_EOF : KIND_BAD_TYPE;
            parse_done = 1'b1;
            queue_expected(r);
            return;
          end
          if (rec_type == REC_EXT_LIN && rec_count == 8'd0) ext_offset = '0;
        end
      endcase
      at_pos = at_pos + 10'd1;
      return;
    end
    // body: pairs, then two checksum characters
    off = at_pos - HDR_END;
    span = {1'b0, rec_count, 1'b0};
    if (off < span) begin
      if (!off[0]) begin
        for (int k = 0; k < LANES; k++) high_nib[4*k +: 4] = char_value(ch[k]);
      end else begin
        last = (word_count + 8'd1) == rec_count;
        for (int k = 0; k < LANES; k++) b[k] = {high_nib[4*k +: 4], char_value(ch[k])};
        if (rec_type == REC_DATA) begin
          r.kind = KIND_DATA;
          r.word_address = {ext_offset, rec_addr};
          r.word_index = word_count;
          r.data_byte0 = b[0];
          r.data_byte1 = b[1];
          r.data_byte2 = b[2];
          r.data_byte3 = b[3];
          r.last_in_record = last;
          queue_expected(r);
        end else begin
          ext_build = {ext_build[7:0], b[0]};
          if (last) ext_offset = ext_build;
        end
        word_count = word_count + 8'd1;
      end
      at_pos = at_pos + 10'd1;
    end else if (off == span) begin
      at_pos = at_pos + 10'd1;
    end else begin
      at_pos = '0;
    end
  endtask

  // Offer one item, wait for it to be taken, then maybe idle
  task automatic send_item(input in_item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    track_parser(it);
    items_sent++;
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Send one whole record; fill < 0 gives random data bytes
  task automatic send_record(input logic [7:0] rtype, input logic [7:0] count,
                             input logic [15:0] addr, input logic [15:0] ext_value,
                             input int fill, input int noise_pct);
    logic [7:0]  hdr [9];
    logic [31:0] bytes;
    int          pairs;
    hdr[0] = $urandom_range(1) ? ":" : rand_char() | 8'h01;
    hdr[1] = noisy(hex_char(count[7:4]), noise_pct);
    hdr[2] = noisy(hex_char(count[3:0]), noise_pct);
    for (int h = 0; h < 4; h++) hdr[3+h] = noisy(hex_char(addr[15-4*h -: 4]), noise_pct);
    // a zero digit of the type may also be any non-hex character
    hdr[7] = (rtype[7:4] == 4'h0 && $urandom_range(3) == 0) ?
             non_hex_char() : hex_char(rtype[7:4]);
    hdr[8] = (rtype[3:0] == 4'h0 && $urandom_range(3) == 0) ?
             non_hex_char() : hex_char(rtype[3:0]);
    for (int h = 0; h < 9; h++) send_item(lane0_item(hdr[h]));
    if (rtype != REC_DATA && rtype != REC_EXT_LIN) return;
    pairs = int'({char_value(hdr[1]), char_value(hdr[2])});
    for (int p = 0; p < pairs; p++) begin
      bytes = (fill >= 0) ? {4{fill[7:0]}} : $urandom();
      // the last two offset bytes come from ext_value
      if (rtype == REC_EXT_LIN) begin
        if (p == pairs - 1) begin
          bytes[7:0] = ext_value[7:0];
        end else if (p == pairs - 2) begin
          bytes[7:0] = ext_value[15:8];
        end
      end
      send_item(pair_item(bytes, 1'b1, noise_pct));
      send_item(pair_item(bytes, 1'b0, noise_pct));
    end
    repeat (2) send_item(lane0_item(rand_char()));
  endtask

  // Compare each taken result with the oldest expectation; stall at random
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(result.kind), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (result.kind !== want.kind)
          report_mismatch("kind", 32'(result.kind), 32'(want.kind));
        if (result.word_address !== want.word_address)
          report_mismatch("word_address", result.word_address, want.word_address);
        if (result.word_index !== want.word_index)
          report_mismatch("word_index", 32'(result.word_index), 32'(want.word_index));
        if (result.data_byte0 !== want.data_byte0)
          report_mismatch("data_byte0", 32'(result.data_byte0), 32'(want.data_byte0));
        if (result.data_byte1 !== want.data_byte1)
          report_mismatch("data_byte1", 32'(result.data_byte1), 32'(want.data_byte1));
        if (result.data_byte2 !== want.data_byte2)
          report_mismatch("data_byte2", 32'(result.data_byte2), 32'(want.data_byte2));
        if (result.data_byte3 !== want.data_byte3)
          report_mismatch("data_byte3", 32'(result.data_byte3), 32'(want.data_byte3));
        if (result.last_in_record !== want.last_in_record)
          report_mismatch("last_in_record", 32'(result.last_in_record),
                          32'(want.last_in_record));
      end
    end
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Data records at address and byte extremes, an empty one and the largest one
  task automatic test_data_records();
    gap_pct = 0;
    stall_pct = 0;
    send_record(REC_DATA, 8'd1, 16'h0000, 16'h0000, 0, 0);
    send_record(REC_DATA, 8'd2, 16'hFFFF, 16'h0000, 255, 0);
    send_record(REC_DATA, 8'd0, 16'h1234, 16'h0000, -1, 0);
    send_record(REC_DATA, 8'd255, 16'($urandom()), 16'h0000, -1, 0);
  endtask

  // Extended linear address records: top offset, accumulation, zero count
  task automatic test_extended_offset();
    gap_pct = 0;
    stall_pct = 0;
    send_record(REC_EXT_LIN, 8'd2, 16'h0000, 16'hFFFF, -1, 0);
    send_record(REC_DATA, 8'd1, 16'hFFFF, 16'h0000, -1, 0);
    send_record(REC_EXT_LIN, 8'd3, 16'($urandom()), 16'h8001, -1, 0);
    send_record(REC_DATA, 8'd3, 16'($urandom()), 16'h0000, -1, 0);
    send_record(REC_EXT_LIN, 8'd0, 16'($urandom()), 16'h0000, -1, 0);
    send_record(REC_DATA, 8'd2, 16'($urandom()), 16'h0000, -1, 0);
    send_record(REC_EXT_LIN, 8'd1, 16'($urandom()), 16'h00A5, -1, 0);
    send_record(REC_DATA, 8'd1, 16'($urandom()), 16'h0000, -1, 0);
  endtask

  // Non-hex characters and stray NULs inside records
  task automatic test_odd_characters();
    gap_pct = 30;
    stall_pct = 30;
    send_record(REC_DATA, 8'd4, 16'($urandom()), 16'h0000, -1, 60);
    send_record(REC_EXT_LIN, 8'd2, 16'($urandom()), 16'($urandom()), -1, 60);
    send_record(REC_DATA, 8'd3, 16'($urandom()), 16'h0000, -1, 100);
  endtask

  // Random image: mostly small data records, some offset records, rare big ones
  task automatic test_random_image(input int target, input int gap, input int stall);
    int start;
    int pick;
    int cnt;
    int noise;
    gap_pct = gap;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = int'($urandom_range(99));
      noise = ($urandom_range(3) == 0) ? int'($urandom_range(1, 20)) : 0;
      if (pick < 15) begin
        send_record(REC_EXT_LIN, 8'($urandom_range(4)), 16'($urandom()), 16'($urandom()),
                    -1, noise);
      end else begin
        cnt = ($urandom_range(59) == 0) ? int'($urandom_range(128, 255)) :
              int'($urandom_range(8));
        send_record(REC_DATA, 8'(cnt), 16'($urandom()), 16'h0000,
                    (pick < 20) ? 0 : (pick < 25) ? 255 : -1, noise);
      end
    end
  endtask

  // End the parse one of three ways, then check that later items are dropped
  task automatic test_termination();
    logic [7:0] t;
    gap_pct = 20;
    stall_pct = 20;
    case ($urandom_range(2))
      0: send_record(REC_EOF, 8'($urandom()), 16'($urandom()), 16'h0000, -1, 0);
      1: begin
        t = rand_char();
        while (t == REC_DATA || t == REC_EOF || t == REC_EXT_LIN) t = rand_char();
        send_record(t, 8'($urandom()), 16'($urandom()), 16'h0000, -1, 0);
      end
      default: send_item(lane0_item(8'h00));
    endcase
    repeat (20) send_item(lane0_item(rand_char()));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_data_records();
    test_extended_offset();
    test_odd_characters();
    test_random_image(220, 0, 0);
    test_random_image(220, 45, 0);
    test_random_image(220, 0, 45);
    test_random_image(220, 36, 36);
    test_termination();
    item_valid <= 1'b0;
    stall_pct = 0;
    // drain, then give stray results time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### intel_hex_four_lane_parser.f
sv/ihex4l_pkg.sv
sv/ihex4l_core.sv
sv/intel_hex_four_lane_parser.sv
test/tb.sv
